FILE: rtl/gup3d_pkg.sv
// Shared constants and register map of the 3D linear grid upsampler.
package gup3d_pkg;

  typedef logic [2:0] reg_idx_t;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int SIZE_W = 7;
  localparam int SKIP_W = 3;
  localparam int FINE_W = 7;

  localparam reg_idx_t REG_SIZE_X    = 3'd0;
  localparam reg_idx_t REG_SIZE_Y    = 3'd1;
  localparam reg_idx_t REG_SIZE_Z    = 3'd2;
  localparam reg_idx_t REG_SKIP_LOW  = 3'd3;
  localparam reg_idx_t REG_SKIP_HIGH = 3'd4;

endpackage

FILE: rtl/gup3d_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gup3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/grid_upsample_3d_linear_top.sv
// Top level of the streaming trilinear upsample-by-two of a 3D grid.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+------------------------------------------
//  apb     | in  | psel/penable/pwrite/pready | size_x, size_y, size_z, skip_low, skip_high
//  s_axis  | in  | s_axis_tvalid/tready       | tdata: sample_value
//  m_axis  | out | m_axis_tvalid/tready       | tdata: fine_x, fine_y, fine_z, out_value;
//          |     |                            | tlast: run_last; tuser: grid_done
//
// Each coarse sample is written to the plane store in its accept cycle while the seven other
// corners of its 2x2x2 cell are read, one per cycle, on the store's single read port.
// Results leave the emitter at one per cycle while the output is not stalled.
// The gather of the next item overlaps the delivery of the current item's results.
// Reset clears position, registers and handshake state; the store is not cleared.
// An output stall holds the result register, then the emitter, then the gather unit,
// which drops s_axis_tready.
module grid_upsample_3d_linear_top #(
  parameter int MAX_N       = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gup3d_pkg::APB_AW-1:0]      paddr,
  input  logic [gup3d_pkg::APB_DW-1:0]      pwdata,
  output logic [gup3d_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // fine_x, fine_y, fine_z, out_value
  output logic [((3*gup3d_pkg::FINE_W+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                              m_axis_tlast,
  // grid_done
  output logic                              m_axis_tuser
);

  localparam int CW    = $clog2(MAX_N);
  localparam int NW    = CW + 1;
  localparam int FW    = CW + 2;
  localparam int AW    = 2 * CW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int ACCW  = SAMPLE_BITS + 3;
  localparam int OW    = ((3 * gup3d_pkg::FINE_W + SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {G_IDLE, G_READ, G_DONE} g_state_e;

  // ---------------------------------------------------------------- configuration
  logic [gup3d_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic [gup3d_pkg::SKIP_W-1:0] skip_lo_q, skip_hi_q;
  gup3d_pkg::reg_idx_t          reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= gup3d_pkg::SIZE_W'(2);
      size_y_q  <= gup3d_pkg::SIZE_W'(2);
      size_z_q  <= gup3d_pkg::SIZE_W'(2);
      skip_lo_q <= '0;
      skip_hi_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gup3d_pkg::REG_SIZE_X:    size_x_q  <= pwdata[gup3d_pkg::SIZE_W-1:0];
        gup3d_pkg::REG_SIZE_Y:    size_y_q  <= pwdata[gup3d_pkg::SIZE_W-1:0];
        gup3d_pkg::REG_SIZE_Z:    size_z_q  <= pwdata[gup3d_pkg::SIZE_W-1:0];
        gup3d_pkg::REG_SKIP_LOW:  skip_lo_q <= pwdata[gup3d_pkg::SKIP_W-1:0];
        gup3d_pkg::REG_SKIP_HIGH: skip_hi_q <= pwdata[gup3d_pkg::SKIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gup3d_pkg::REG_SIZE_X:    prdata = gup3d_pkg::APB_DW'(size_x_q);
      gup3d_pkg::REG_SIZE_Y:    prdata = gup3d_pkg::APB_DW'(size_y_q);
      gup3d_pkg::REG_SIZE_Z:    prdata = gup3d_pkg::APB_DW'(size_z_q);
      gup3d_pkg::REG_SKIP_LOW:  prdata = gup3d_pkg::APB_DW'(skip_lo_q);
      gup3d_pkg::REG_SKIP_HIGH: prdata = gup3d_pkg::APB_DW'(skip_hi_q);
      default:                  prdata = '0;
    endcase
  end

  // clamp sizes into [2, MAX_N]
  function automatic logic [NW-1:0] eff_size(input logic [gup3d_pkg::SIZE_W-1:0] s);
    logic [NW-1:0] r;
    if (s < gup3d_pkg::SIZE_W'(2)) r = NW'(2);
    else if (32'(s) > MAX_N)       r = NW'(MAX_N);
    else                           r = NW'(s);
    return r;
  endfunction

  // bit 0: odd point 2c-1 kept, bit 1: even point 2c kept
  function automatic logic [1:0] axis_ok(input logic [CW-1:0] c, input logic [NW-1:0] n,
                                         input logic lo, input logic hi);
    logic [FW-1:0] top;
    logic [FW-1:0] two_c;
    logic [1:0]    r;
    top   = {n, 1'b0} - FW'(3) + FW'(hi);
    two_c = {1'b0, c, 1'b0};
    r[0]  = (c != '0) && ((two_c - FW'(1)) <= top);
    r[1]  = (two_c >= FW'(lo)) && (two_c <= top);
    return r;
  endfunction

  logic [NW-1:0] n_x, n_y, n_z;
  assign n_x = eff_size(size_x_q);
  assign n_y = eff_size(size_y_q);
  assign n_z = eff_size(size_z_q);

  // ---------------------------------------------------------------- position
  logic [CW-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [NW-1:0] inc_x, inc_y, inc_z;
  logic          s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign inc_x    = NW'(pos_x_q) + NW'(1);
  assign inc_y    = NW'(pos_y_q) + NW'(1);
  assign inc_z    = NW'(pos_z_q) + NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (s_accept) begin
      if (inc_z >= n_z) begin
        pos_z_q <= '0;
        if (inc_y >= n_y) begin
          pos_y_q <= '0;
          pos_x_q <= (inc_x >= n_x) ? '0 : CW'(inc_x);
        end else begin
          pos_y_q <= CW'(inc_y);
        end
      end else begin
        pos_z_q <= CW'(inc_z);
      end
    end
  end

  // result mask of the arriving item; code bit 2 x, bit 1 y, bit 0 z, 0 = odd point
  logic [1:0] ok_x, ok_y, ok_z;
  logic [7:0] new_mask;
  logic       new_glast;

  assign ok_x = axis_ok(pos_x_q, n_x, skip_lo_q[0], skip_hi_q[0]);
  assign ok_y = axis_ok(pos_y_q, n_y, skip_lo_q[1], skip_hi_q[1]);
  assign ok_z = axis_ok(pos_z_q, n_z, skip_lo_q[2], skip_hi_q[2]);
  assign new_glast = (NW'(pos_x_q) == n_x - NW'(1)) && (NW'(pos_y_q) == n_y - NW'(1)) &&
                     (NW'(pos_z_q) == n_z - NW'(1));

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      new_mask[k] = ok_x[k / 4] & ok_y[(k / 2) % 2] & ok_z[k % 2];
    end
  end

  // ---------------------------------------------------------------- gather unit
  g_state_e       g_state_q;
  logic [2:0]     g_rd_cnt_q;
  logic [CW-1:0]  g_cx_q, g_cy_q, g_cz_q;
  logic [2:0]     g_lo_q;
  logic [7:0]     g_mask_q;
  logic           g_glast_q;
  logic           rdat_vld_q;
  logic [2:0]     rdat_idx_q;
  logic           handoff;
  logic           hand_ok;

  logic signed [ACCW-1:0] g_acc_q   [8];
  logic signed [ACCW-1:0] g_acc_sum [8];
  logic signed [ACCW-1:0] smp_ext;
  logic signed [ACCW-1:0] rd_ext;

  logic [2:0]             rd_corner;
  logic [CW-1:0]          rd_cx, rd_cy, rd_cz;
  logic [AW-1:0]          raddr, waddr;
  logic [SAMPLE_BITS-1:0] rdata;

  assign s_axis_tready = (g_state_q == G_IDLE) || handoff;
  assign handoff       = (g_state_q == G_DONE) && hand_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_state_q  <= G_IDLE;
      g_rd_cnt_q <= '0;
    end else begin
      case (g_state_q)
        G_IDLE: begin
          if (s_accept) begin
            g_state_q  <= G_READ;
            g_rd_cnt_q <= 3'd1;
          end
        end
        G_READ: begin
          g_rd_cnt_q <= g_rd_cnt_q + 3'd1;
          if (g_rd_cnt_q == 3'd6) begin
            g_state_q <= G_DONE;
          end
        end
        G_DONE: begin
          if (s_accept) begin
            g_state_q  <= G_READ;
            g_rd_cnt_q <= 3'd1;
          end else if (handoff) begin
            g_state_q <= G_IDLE;
          end
        end
        default: g_state_q <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdat_vld_q <= 1'b0;
    end else begin
      rdat_vld_q <= s_accept || (g_state_q == G_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    rdat_idx_q <= rd_corner;
    if (s_accept) begin
      g_cx_q    <= pos_x_q;
      g_cy_q    <= pos_y_q;
      g_cz_q    <= pos_z_q;
      g_lo_q    <= skip_lo_q;
      g_mask_q  <= new_mask;
      g_glast_q <= new_glast;
    end
    for (int k = 0; k < 8; k++) begin
      g_acc_q[k] <= s_accept ? smp_ext : g_acc_sum[k];
    end
  end

  // corner 0 is read speculatively while waiting for the next sample
  assign rd_corner = (g_state_q == G_READ) ? g_rd_cnt_q : 3'd0;
  assign rd_cx     = (g_state_q == G_READ) ? g_cx_q : pos_x_q;
  assign rd_cy     = (g_state_q == G_READ) ? g_cy_q : pos_y_q;
  assign rd_cz     = (g_state_q == G_READ) ? g_cz_q : pos_z_q;

  assign raddr = {rd_corner[2] ? rd_cx[0] : ~rd_cx[0],
                  rd_corner[1] ? rd_cy : rd_cy - CW'(1),
                  rd_corner[0] ? rd_cz : rd_cz - CW'(1)};
  assign waddr = {pos_x_q[0], pos_y_q, pos_z_q};

  gup3d_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (s_accept),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign smp_ext = {{3{s_axis_tdata[SAMPLE_BITS-1]}}, s_axis_tdata[SAMPLE_BITS-1:0]};
  assign rd_ext  = {{3{rdata[SAMPLE_BITS-1]}}, rdata};

  // a corner counts toward a sum when each axis is odd or the corner sits on the current side
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (rdat_vld_q &&
          (rdat_idx_q[2] || !k[2]) && (rdat_idx_q[1] || !k[1]) && (rdat_idx_q[0] || !k[0])) begin
        g_acc_sum[k] = g_acc_q[k] + rd_ext;
      end else begin
        g_acc_sum[k] = g_acc_q[k];
      end
    end
  end

  // ---------------------------------------------------------------- emitter
  logic signed [ACCW-1:0] e_acc_q [8];
  logic [7:0]             e_mask_q;
  logic [7:0]             e_mask_clr;
  logic [7:0]             e_mask_after;
  logic [CW-1:0]          e_cx_q, e_cy_q, e_cz_q;
  logic [2:0]             e_lo_q;
  logic                   e_glast_q;
  logic [2:0]             k_sel;
  logic [1:0]             k_zeros;
  logic                   out_load;
  logic                   out_valid_q;
  logic signed [ACCW-1:0] sel_sum;
  logic [SAMPLE_BITS-1:0] sel_val;
  logic [FW-1:0]          f_x, f_y, f_z;

  always_comb begin
    k_sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (e_mask_q[k]) k_sel = 3'(k);
    end
  end

  assign e_mask_clr   = e_mask_q & ~(8'd1 << k_sel);
  assign out_load     = (e_mask_q != '0) && (!out_valid_q || m_axis_tready);
  assign e_mask_after = out_load ? e_mask_clr : e_mask_q;
  assign hand_ok      = (e_mask_after == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_mask_q <= '0;
    end else begin
      e_mask_q <= handoff ? g_mask_q : e_mask_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      for (int k = 0; k < 8; k++) begin
        e_acc_q[k] <= g_acc_sum[k];
      end
      e_cx_q    <= g_cx_q;
      e_cy_q    <= g_cy_q;
      e_cz_q    <= g_cz_q;
      e_lo_q    <= g_lo_q;
      e_glast_q <= g_glast_q;
    end
  end

  // a sum of 2^m corners: m is the count of odd axes
  assign k_zeros = 2'($countones(~k_sel));
  assign sel_sum = e_acc_q[k_sel];
  assign sel_val = SAMPLE_BITS'(sel_sum >>> k_zeros);

  assign f_x = {1'b0, e_cx_q, 1'b0} + FW'(k_sel[2]) - FW'(1) - FW'(e_lo_q[0]);
  assign f_y = {1'b0, e_cy_q, 1'b0} + FW'(k_sel[1]) - FW'(1) - FW'(e_lo_q[1]);
  assign f_z = {1'b0, e_cz_q, 1'b0} + FW'(k_sel[0]) - FW'(1) - FW'(e_lo_q[2]);

  // ---------------------------------------------------------------- output register
  logic [OW-1:0] out_data_q;
  logic          out_last_q;
  logic          out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OW'({sel_val, gup3d_pkg::FINE_W'(f_z), gup3d_pkg::FINE_W'(f_y),
                         gup3d_pkg::FINE_W'(f_x)});
      out_last_q <= (e_mask_clr == '0);
      out_done_q <= (e_mask_clr == '0) && e_glast_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  // ---------------------------------------------------------------- checks
  a_rdat_in_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdat_vld_q |-> (g_state_q == G_READ || g_state_q == G_DONE))
    else $error("corner data arrived outside a gather");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_state_q == G_DONE && !hand_ok) |=> (g_state_q == G_DONE))
    else $error("gathered sums left before the emitter was free");

  a_read_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_state_q == G_READ && g_rd_cnt_q == 3'd6) |=> (g_state_q == G_DONE))
    else $error("gather did not end after the last corner read");

  a_one_per_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !handoff) |=>
      ($countones(e_mask_q) == $countones($past(e_mask_q)) - 1))
    else $error("emitter dropped or repeated a result");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the streaming 3D linear grid upsampler.
`timescale 1ns / 100ps

module testbench;

  localparam int GRID_MAX     = 64;
  localparam int VALUE_W      = 32;
  localparam int IN_W         = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_W        = ((3 * gup3d_pkg::FINE_W + VALUE_W + 7) / 8) * 8;
  localparam int STALL_MAX    = 12;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_GOAL    = 440;

  typedef struct {
    logic [gup3d_pkg::FINE_W-1:0] fx;
    logic [gup3d_pkg::FINE_W-1:0] fy;
    logic [gup3d_pkg::FINE_W-1:0] fz;
    logic [VALUE_W-1:0]           value;
    logic                         last;
    logic                         done;
  } fine_pt_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gup3d_pkg::APB_AW-1:0]   paddr;
  logic [gup3d_pkg::APB_DW-1:0]   pwdata;
  logic [gup3d_pkg::APB_DW-1:0]   prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [IN_W-1:0]                s_axis_tdata;   // sample_value
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [OUT_W-1:0]               m_axis_tdata;   // fine_x, fine_y, fine_z, out_value
  logic                           m_axis_tlast;   // run_last
  logic                           m_axis_tuser;   // grid_done

  // Shadow of the configuration and the coarse position.
  logic [gup3d_pkg::SIZE_W-1:0]   cfg_size [3] = '{7'd2, 7'd2, 7'd2};
  logic [gup3d_pkg::SKIP_W-1:0]   cfg_skip_lo = '0;
  logic [gup3d_pkg::SKIP_W-1:0]   cfg_skip_hi = '0;
  int                             pos_x = 0;
  int                             pos_y = 0;
  int                             pos_z = 0;
  logic [VALUE_W-1:0]             plane_mem [2*GRID_MAX*GRID_MAX];

  fine_pt_t             pending_points [$];

  bit                   src_steady  = 1'b0;
  bit                   sink_steady = 1'b0;
  int                   sink_hold   = 0;
  int                   n_items     = 0;
  int                   n_checked   = 0;
  int                   n_grids     = 0;
  int                   n_errors    = 0;

  grid_upsample_3d_linear_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int eff_size(input logic [gup3d_pkg::SIZE_W-1:0] s);
    if (s < 2) return 2;
    if (s > GRID_MAX) return GRID_MAX;
    return int'(s);
  endfunction

  function automatic int mem_addr(input int x, input int y, input int z);
    return (x & 1) * GRID_MAX * GRID_MAX + (y % GRID_MAX) * GRID_MAX + (z % GRID_MAX);
  endfunction

  function automatic logic [31:0] shadow_reg(input gup3d_pkg::reg_idx_t idx);
    case (idx)
      gup3d_pkg::REG_SIZE_X:    return 32'(cfg_size[0]);
      gup3d_pkg::REG_SIZE_Y:    return 32'(cfg_size[1]);
      gup3d_pkg::REG_SIZE_Z:    return 32'(cfg_size[2]);
      gup3d_pkg::REG_SKIP_LOW:  return 32'(cfg_skip_lo);
      gup3d_pkg::REG_SKIP_HIGH: return 32'(cfg_skip_hi);
      default:                  return '0;
    endcase
  endfunction

  // Store the sample, then queue every fine point whose last corner it is.
  function automatic void predict_fine_points(input logic [VALUE_W-1:0] sample);
    int       n [3];
    int       c [3];
    int       k [3];
    int       f [3][2];
    int       base [3][2];
    int       span [3][2];
    int       lo, hi, top, shift, cnt;
    longint   acc;
    fine_pt_t pts [8];
    c[0] = pos_x;
    c[1] = pos_y;
    c[2] = pos_z;
    cnt = 0;
    plane_mem[mem_addr(c[0], c[1], c[2])] = sample;
    for (int d = 0; d < 3; d++) begin
      n[d] = eff_size(cfg_size[d]);
      lo = int'(cfg_skip_lo[d]);
      hi = int'(cfg_skip_hi[d]);
      top = 2 * n[d] - 3 + hi;
      k[d] = 0;
      if (c[d] > 0 && 2 * c[d] - 1 >= lo && 2 * c[d] - 1 <= top) begin
        f[d][k[d]] = 2 * c[d] - 1 - lo;
        base[d][k[d]] = c[d] - 1;
        span[d][k[d]] = 2;
        k[d]++;
      end
      if (2 * c[d] >= lo && 2 * c[d] <= top) begin
        f[d][k[d]] = 2 * c[d] - lo;
        base[d][k[d]] = c[d];
        span[d][k[d]] = 1;
        k[d]++;
      end
    end
    for (int i = 0; i < k[0]; i++) begin
      for (int j = 0; j < k[1]; j++) begin
        for (int l = 0; l < k[2]; l++) begin
          acc = 0;
          shift = span[0][i] + span[1][j] + span[2][l] - 3;
          for (int a = 0; a < span[0][i]; a++)
            for (int b = 0; b < span[1][j]; b++)
              for (int e = 0; e < span[2][l]; e++)
                acc += longint'($signed(
                  plane_mem[mem_addr(base[0][i] + a, base[1][j] + b, base[2][l] + e)]));
          pts[cnt].fx    = gup3d_pkg::FINE_W'(f[0][i]);
          pts[cnt].fy    = gup3d_pkg::FINE_W'(f[1][j]);
          pts[cnt].fz    = gup3d_pkg::FINE_W'(f[2][l]);
          pts[cnt].value = VALUE_W'(acc >>> shift);
          pts[cnt].last  = 1'b0;
          pts[cnt].done  = 1'b0;
          cnt++;
        end
      end
    end
    if (cnt > 0) begin
      pts[cnt-1].last = 1'b1;
      if (c[0] == n[0] - 1 && c[1] == n[1] - 1 && c[2] == n[2] - 1)
        pts[cnt-1].done = 1'b1;
    end
    for (int i = 0; i < cnt; i++) pending_points.push_back(pts[i]);
    // A counter at or past its size wraps on this advance.
    pos_z++;
    if (pos_z >= n[2]) begin
      pos_z = 0;
      pos_y++;
      if (pos_y >= n[1]) begin
        pos_y = 0;
        pos_x++;
        if (pos_x >= n[0]) pos_x = 0;
      end
    end
  endfunction

  function automatic logic [VALUE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return VALUE_W'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom();
    endcase
  endfunction

  task automatic apb_write(input gup3d_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      gup3d_pkg::REG_SIZE_X:    cfg_size[0] = value[gup3d_pkg::SIZE_W-1:0];
      gup3d_pkg::REG_SIZE_Y:    cfg_size[1] = value[gup3d_pkg::SIZE_W-1:0];
      gup3d_pkg::REG_SIZE_Z:    cfg_size[2] = value[gup3d_pkg::SIZE_W-1:0];
      gup3d_pkg::REG_SKIP_LOW:  cfg_skip_lo = value[gup3d_pkg::SKIP_W-1:0];
      gup3d_pkg::REG_SKIP_HIGH: cfg_skip_hi = value[gup3d_pkg::SKIP_W-1:0];
      default:                  ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input gup3d_pkg::reg_idx_t idx, input string name);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== shadow_reg(idx)) begin
      $error("%s: expected %0d, got %0d", name, shadow_reg(idx), got);
      n_errors++;
    end
  endtask

  // Drop valid, wait for every queued point, then let the gather unit finish.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input int sx, input int sy, input int sz,
                           input int lo, input int hi);
    settle();
    apb_write(gup3d_pkg::REG_SIZE_X, 32'(sx));
    apb_write(gup3d_pkg::REG_SIZE_Y, 32'(sy));
    apb_write(gup3d_pkg::REG_SIZE_Z, 32'(sz));
    apb_write(gup3d_pkg::REG_SKIP_LOW, 32'(lo));
    apb_write(gup3d_pkg::REG_SKIP_HIGH, 32'(hi));
  endtask

  task automatic send_sample(input logic [VALUE_W-1:0] value);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_fine_points(value);
    n_items++;
  endtask

  // Send one whole grid; optionally change the skip flags partway through.
  task automatic run_grid(input bit reskip);
    int total, cut;
    total = eff_size(cfg_size[0]) * eff_size(cfg_size[1]) * eff_size(cfg_size[2]);
    cut = reskip ? $urandom_range(1, total - 1) : total;
    for (int s = 0; s < total; s++) begin
      if (s == cut) begin
        settle();
        apb_write(gup3d_pkg::REG_SKIP_LOW, $urandom_range(0, 7));
        apb_write(gup3d_pkg::REG_SKIP_HIGH, $urandom_range(0, 7));
      end
      send_sample(draw_sample());
    end
  endtask

  task automatic test_register_access();
    check_reg(gup3d_pkg::REG_SIZE_X, "size_x");
    check_reg(gup3d_pkg::REG_SIZE_Y, "size_y");
    check_reg(gup3d_pkg::REG_SIZE_Z, "size_z");
    check_reg(gup3d_pkg::REG_SKIP_LOW, "skip_low");
    check_reg(gup3d_pkg::REG_SKIP_HIGH, "skip_high");
    configure(127, 0, 64, 7, 7);
    check_reg(gup3d_pkg::REG_SIZE_X, "size_x");
    check_reg(gup3d_pkg::REG_SIZE_Y, "size_y");
    check_reg(gup3d_pkg::REG_SIZE_Z, "size_z");
    check_reg(gup3d_pkg::REG_SKIP_LOW, "skip_low");
    check_reg(gup3d_pkg::REG_SKIP_HIGH, "skip_high");
  endtask

  task automatic test_corner_values();
    logic [VALUE_W-1:0] rails [8] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000};
    logic [VALUE_W-1:0] odd_mix [8] = '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1,
                                        32'd0, 32'd3, 32'hFFFF_FFFE, 32'd5};
    // Full fine grid including the final point, sums at both rails.
    configure(2, 2, 2, 0, 7);
    foreach (rails[i]) send_sample(rails[i]);
    // Sizes below the minimum, only the cell center kept: floor of a mixed-sign mean.
    configure(0, 1, 0, 7, 0);
    foreach (odd_mix[i]) send_sample(odd_mix[i]);
  endtask

  task automatic test_midgrid_change();
    configure(2, 2, 4, 0, 0);
    repeat (3) send_sample(draw_sample());
    // z now sits past the new size: no output for it, and it wraps on advance.
    settle();
    apb_write(gup3d_pkg::REG_SIZE_Z, 32'd2);
    apb_write(gup3d_pkg::REG_SKIP_LOW, 32'd5);
    apb_write(gup3d_pkg::REG_SKIP_HIGH, 32'd7);
    repeat (7) send_sample(draw_sample());
  endtask

  task automatic test_output_backpressure();
    configure(3, 3, 4, 0, 7);
    src_steady = 1'b1;
    sink_hold  = HOLD_CYCLES;
    run_grid(1'b0);
    src_steady = 1'b0;
  endtask

  task automatic test_random_grids();
    int wide;
    int sz [3];
    // One grid with an axis at or beyond the largest size.
    wide = $urandom_range(0, 2);
    foreach (sz[d]) sz[d] = (d == wide) ? $urandom_range(GRID_MAX, 127) : $urandom_range(0, 2);
    configure(sz[0], sz[1], sz[2], $urandom_range(0, 7), $urandom_range(0, 7));
    run_grid(1'b0);
    while (n_items < ITEM_GOAL) begin
      foreach (sz[d]) sz[d] = $urandom_range(0, 4);
      configure(sz[0], sz[1], sz[2], $urandom_range(0, 7), $urandom_range(0, 7));
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      run_grid($urandom_range(0, 3) == 0);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : result_check
    fine_pt_t                     want;
    logic [gup3d_pkg::FINE_W-1:0] gx, gy, gz;
    logic [VALUE_W-1:0]           gv;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      gx = m_axis_tdata[gup3d_pkg::FINE_W-1:0];
      gy = m_axis_tdata[2*gup3d_pkg::FINE_W-1:gup3d_pkg::FINE_W];
      gz = m_axis_tdata[3*gup3d_pkg::FINE_W-1:2*gup3d_pkg::FINE_W];
      gv = m_axis_tdata[3*gup3d_pkg::FINE_W+VALUE_W-1:3*gup3d_pkg::FINE_W];
      if (pending_points.size() == 0) begin
        $error("unexpected transfer: fine %0d/%0d/%0d value %0h", gx, gy, gz, gv);
        n_errors++;
      end else begin
        want = pending_points.pop_front();
        n_checked++;
        if (want.done) n_grids++;
        if (gx !== want.fx) begin
          $error("fine_x: expected %0d, got %0d", want.fx, gx);
          n_errors++;
        end
        if (gy !== want.fy) begin
          $error("fine_y: expected %0d, got %0d", want.fy, gy);
          n_errors++;
        end
        if (gz !== want.fz) begin
          $error("fine_z: expected %0d, got %0d", want.fz, gz);
          n_errors++;
        end
        if (gv !== want.value) begin
          $error("out_value: expected %0h, got %0h", want.value, gv);
          n_errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
          n_errors++;
        end
        if (m_axis_tuser !== want.done) begin
          $error("grid_done: expected %0b, got %0b", want.done, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_access();
    test_corner_values();
    test_midgrid_change();
    test_output_backpressure();
    test_random_grids();
    settle();

    $display("Sent %0d coarse samples, checked %0d fine points over %0d completed grids,",
             n_items, n_checked, n_grids);
    $display("with size clamping, skip flags, mid-grid changes and a long output stall.");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
